>>> rtl/btp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btp_pkg
// Shared types and constants for the Z80 branch target predictor pipeline.
// ----------------------------------------------------------------------------
package btp_pkg;

   // code window
   localparam int WINDOW_BYTES = 8;
   localparam int CodeW        = 64;
   localparam int IdxW         = $clog2(WINDOW_BYTES);

   // prefix and opcode values
   localparam logic [7:0] OP_PREFIX_IX = 8'hDD;
   localparam logic [7:0] OP_PREFIX_IY = 8'hFD;
   localparam logic [7:0] OP_PREFIX_ED = 8'hED;
   localparam logic [7:0] OP_HALT      = 8'h76;
   localparam logic [7:0] OP_RET       = 8'hC9;
   localparam logic [7:0] OP_JP        = 8'hC3;
   localparam logic [7:0] OP_CALL      = 8'hCD;
   localparam logic [7:0] OP_JP_IND    = 8'hE9;
   localparam logic [7:0] OP_NOP       = 8'h00;
   localparam logic [7:0] OP_EX_AF     = 8'h08;
   localparam logic [7:0] OP_DJNZ      = 8'h10;
   localparam logic [7:0] OP_JR        = 8'h18;

   // opcode group masks and match values
   localparam logic [7:0] MASK_BLOCK   = 8'hF4;
   localparam logic [7:0] MATCH_BLOCK  = 8'hB0;
   localparam logic [7:0] MASK_GROUP   = 8'hC7;
   localparam logic [7:0] MATCH_RETI   = 8'h45;
   localparam logic [7:0] MATCH_RETCC  = 8'hC0;
   localparam logic [7:0] MATCH_JPCC   = 8'hC2;
   localparam logic [7:0] MATCH_CALLCC = 8'hC4;
   localparam logic [7:0] MATCH_RST    = 8'hC7;
   localparam logic [7:0] MATCH_REL    = 8'h00;
   localparam logic [7:0] MASK_COND    = 8'hC1;
   localparam logic [7:0] MATCH_COND   = 8'hC0;
   localparam logic [7:0] MASK_RST_VEC = 8'h38;

   // flag bit positions in F
   localparam int FLAG_S_BIT  = 7;
   localparam int FLAG_Z_BIT  = 6;
   localparam int FLAG_PV_BIT = 2;
   localparam int FLAG_C_BIT  = 0;

   // condition field of the cc opcodes
   typedef enum logic [1:0] {
      CC_Z  = 2'b00,
      CC_C  = 2'b01,
      CC_PV = 2'b10,
      CC_S  = 2'b11
   } cond_type;

   // source of the branch target
   typedef enum logic [2:0] {
      TS_NONE  = 3'd0,
      TS_STACK = 3'd1,
      TS_BASE  = 3'd2,
      TS_WORD  = 3'd3,
      TS_REL   = 3'd4,
      TS_RST   = 3'd5
   } target_sel_type;

   // after the prefix scan
   typedef struct packed {
      logic            found;
      logic            ed;
      logic [IdxW-1:0] idx;
      logic [7:0]      op;
      logic [7:0]      d1;
      logic [7:0]      d2;
      logic            have1;
      logic            have2;
      logic [15:0]     pc;
      logic [7:0]      flags;
      logic [7:0]      reg_b;
      logic [15:0]     base;
      logic [15:0]     stack_word;
   } scan_type;

   // after decode
   typedef struct packed {
      target_sel_type  tsel;
      logic [15:0]     rel_addr;
      logic [15:0]     word_addr;
      logic [2:0]      rst_vec;
      logic [15:0]     base;
      logic [15:0]     stack_word;
      logic            is_branch;
      logic            from_register;
      logic            is_call;
      logic            is_loop;
      logic            is_block;
      logic            window_short;
   } decode_type;

   // result beat
   typedef struct packed {
      logic [15:0] target_addr;
      logic        is_branch;
      logic        from_register;
      logic        is_call;
      logic        is_loop;
      logic        is_block;
      logic        window_short;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/btp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btp_req_if / btp_rsp_if
// Valid/ready channels carrying request and result beats of the predictor.
// ----------------------------------------------------------------------------
interface btp_req_if;
   import btp_pkg::*;

   logic             valid;
   logic             ready;
   logic [CodeW-1:0] code_bytes;
   logic [15:0]      pc;
   logic [7:0]       flags_reg;
   logic [7:0]       reg_b;
   logic [15:0]      reg_hl;
   logic [15:0]      reg_ix;
   logic [15:0]      reg_iy;
   logic [15:0]      stack_word;

   modport source (
      output valid, code_bytes, pc, flags_reg, reg_b, reg_hl, reg_ix, reg_iy, stack_word,
      input  ready
   );
   modport sink (
      input  valid, code_bytes, pc, flags_reg, reg_b, reg_hl, reg_ix, reg_iy, stack_word,
      output ready
   );
endinterface

interface btp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] target_addr;
   logic        is_branch;
   logic        from_register;
   logic        is_call;
   logic        is_loop;
   logic        is_block;
   logic        window_short;

   modport source (
      output valid, target_addr, is_branch, from_register, is_call, is_loop, is_block,
             window_short,
      input  ready
   );
   modport sink (
      input  valid, target_addr, is_branch, from_register, is_call, is_loop, is_block,
             window_short,
      output ready
   );
endinterface
`default_nettype wire

>>> rtl/btp_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btp_scan
// Prefix scan: finds the first non-prefix byte in the code window, picks the
// index register for the last DD/FD and notes any ED prefix.
// ----------------------------------------------------------------------------
module btp_scan (
   input  wire logic [btp_pkg::CodeW-1:0] code_bytes,
   input  wire logic [15:0]               pc,
   input  wire logic [7:0]                flags_reg,
   input  wire logic [7:0]                reg_b,
   input  wire logic [15:0]               reg_hl,
   input  wire logic [15:0]               reg_ix,
   input  wire logic [15:0]               reg_iy,
   input  wire logic [15:0]               stack_word,
   output btp_pkg::scan_type              scan
);
   import btp_pkg::*;

   logic [7:0] win [WINDOW_BYTES+2];

   // window bytes, padded past the end
   always_comb begin
      for (int k = 0; k < WINDOW_BYTES + 2; k++) begin
         if (k < WINDOW_BYTES) begin
            win[k] = code_bytes[8*k +: 8];
         end else begin
            win[k] = 8'h00;
         end
      end
   end

   // first opcode byte and its operand bytes
   always_comb begin
      scan.found      = 1'b0;
      scan.ed         = 1'b0;
      scan.idx        = '0;
      scan.op         = 8'h00;
      scan.d1         = 8'h00;
      scan.d2         = 8'h00;
      scan.have1      = 1'b0;
      scan.have2      = 1'b0;
      scan.pc         = pc;
      scan.flags      = flags_reg;
      scan.reg_b      = reg_b;
      scan.base       = reg_hl;
      scan.stack_word = stack_word;
      for (int k = 0; k < WINDOW_BYTES; k++) begin
         if (!scan.found) begin
            if (win[k] == OP_PREFIX_IX) begin
               scan.base = reg_ix;
            end else if (win[k] == OP_PREFIX_IY) begin
               scan.base = reg_iy;
            end else if (win[k] == OP_PREFIX_ED) begin
               scan.ed = 1'b1;
            end else begin
               scan.found = 1'b1;
               scan.idx   = IdxW'(k);
               scan.op    = win[k];
               scan.d1    = win[k+1];
               scan.d2    = win[k+2];
               scan.have1 = (k + 1 < WINDOW_BYTES);
               scan.have2 = (k + 2 < WINDOW_BYTES);
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/btp_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btp_decode
// Opcode decode: classifies the instruction, evaluates its condition and
// forms the relative target, pc + offset of next instruction + displacement.
// ----------------------------------------------------------------------------
module btp_decode (
   input  wire btp_pkg::scan_type scan,
   output btp_pkg::decode_type    dec
);
   import btp_pkg::*;

   logic [7:0] op;
   logic       cc_flag;
   logic       cc_holds;
   logic       jr_flag;
   logic       jr_holds;
   logic       jp_hit;
   logic       jp_call;
   logic       jp_loop;

   assign op = scan.op;

   // condition of ret/jp/call cc
   always_comb begin
      unique case (cond_type'(op[5:4]))
         CC_Z:    cc_flag = scan.flags[FLAG_Z_BIT];
         CC_C:    cc_flag = scan.flags[FLAG_C_BIT];
         CC_PV:   cc_flag = scan.flags[FLAG_PV_BIT];
         CC_S:    cc_flag = scan.flags[FLAG_S_BIT];
         default: cc_flag = 1'b0;
      endcase
   end
   assign cc_holds = cc_flag ~^ op[3];

   // condition of jr cc: only Z and C
   assign jr_flag  = op[4] ? scan.flags[FLAG_C_BIT] : scan.flags[FLAG_Z_BIT];
   assign jr_holds = jr_flag ~^ op[3];

   // instruction class
   always_comb begin
      // relative target and absolute word
      dec.rel_addr      = scan.pc + 16'(scan.idx) + 16'd2 + {{8{scan.d1[7]}}, scan.d1};
      dec.word_addr     = {scan.d2, scan.d1};
      dec.rst_vec       = op[5:3];
      dec.base          = scan.base;
      dec.stack_word    = scan.stack_word;
      dec.tsel          = TS_NONE;
      dec.is_branch     = 1'b0;
      dec.from_register = 1'b0;
      dec.is_call       = 1'b0;
      dec.is_loop       = 1'b0;
      dec.is_block      = 1'b0;
      dec.window_short  = 1'b0;
      jp_hit            = 1'b0;
      jp_call           = 1'b0;
      jp_loop           = 1'b0;
      priority if (!scan.found) begin
         dec.window_short = 1'b1;
      end else if (op == OP_HALT) begin
         dec.is_block = 1'b1;
      end else if (scan.ed) begin
         if ((op & MASK_BLOCK) == MATCH_BLOCK) begin
            dec.is_block = 1'b1;
         end else if ((op & MASK_GROUP) == MATCH_RETI) begin
            dec.tsel          = TS_STACK;
            dec.is_branch     = 1'b1;
            dec.from_register = 1'b1;
         end
      end else if (op == OP_RET) begin
         dec.tsel          = TS_STACK;
         dec.is_branch     = 1'b1;
         dec.from_register = 1'b1;
      end else if (op == OP_JP) begin
         jp_hit = 1'b1;
      end else if (op == OP_CALL) begin
         jp_hit  = 1'b1;
         jp_call = 1'b1;
      end else if ((op & MASK_COND) == MATCH_COND) begin
         if (cc_holds) begin
            if ((op & MASK_GROUP) == MATCH_RETCC) begin
               dec.tsel          = TS_STACK;
               dec.is_branch     = 1'b1;
               dec.from_register = 1'b1;
            end else if ((op & MASK_GROUP) == MATCH_CALLCC) begin
               jp_hit  = 1'b1;
               jp_call = 1'b1;
            end else if ((op & MASK_GROUP) == MATCH_JPCC) begin
               jp_hit  = 1'b1;
               jp_loop = 1'b1;
            end
         end
      end else if (op == OP_JP_IND) begin
         dec.tsel          = TS_BASE;
         dec.is_branch     = 1'b1;
         dec.from_register = 1'b1;
      end else if ((op & MASK_GROUP) == MATCH_RST) begin
         dec.tsel      = TS_RST;
         dec.is_branch = 1'b1;
         dec.is_call   = 1'b1;
      end else if ((op & MASK_GROUP) == MATCH_REL) begin
         if ((op != OP_NOP) && (op != OP_EX_AF)) begin
            if (!scan.have1) begin
               dec.window_short = 1'b1;
            end else if (op == OP_JR) begin
               dec.tsel      = TS_REL;
               dec.is_branch = 1'b1;
            end else if (op == OP_DJNZ) begin
               if (scan.reg_b != 8'd1) begin
                  dec.tsel      = TS_REL;
                  dec.is_branch = 1'b1;
                  dec.is_loop   = 1'b1;
               end
            end else if (jr_holds) begin
               dec.tsel      = TS_REL;
               dec.is_branch = 1'b1;
               dec.is_loop   = 1'b1;
            end
         end
      end else begin
         // any other opcode selects no target and leaves every flag clear
      end

      // two-byte address operand
      if (jp_hit) begin
         if (!scan.have2) begin
            dec.window_short = 1'b1;
         end else begin
            dec.tsel      = TS_WORD;
            dec.is_branch = 1'b1;
            dec.is_call   = jp_call;
            dec.is_loop   = jp_loop;
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/z80_branch_target_predict_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// z80_branch_target_predict_core
// Predicts whether the Z80 instruction at pc branches and where it goes.
// ----------------------------------------------------------------------------
// The core takes one request beat per cycle when not stalled and returns one
// result beat for each, in order, through the scan, decode and output
// registers. Stage one scans the code window for DD/FD/ED prefixes, stage
// two decodes the opcode, tests its condition and adds the relative
// offset, and stage three selects the target into the output register.
// Each stage has its own valid bit and ready is chained back from the
// output, so empty stages fill while a finished result waits and the
// sustained rate is one beat per cycle when not stalled. The result is a
// pure function of the request beat; there is no state kept between beats.
module z80_branch_target_predict_core (
   input  wire logic  clock,
   input  wire logic  reset,
   btp_req_if.sink    req_bus,
   btp_rsp_if.source  rsp_bus
);
   import btp_pkg::*;

   scan_type   scan_out;
   decode_type dec_out;
   result_type res_sel;

   logic       s1_valid_ff, s1_valid_in;
   logic       s2_valid_ff, s2_valid_in;
   logic       s3_valid_ff, s3_valid_in;
   scan_type   s1_ff, s1_in;
   decode_type s2_ff, s2_in;
   result_type s3_ff, s3_in;

   logic       s1_ready;
   logic       s2_ready;
   logic       s3_ready;

   // stage one: prefix scan
   btp_scan u_scan (
      .code_bytes (req_bus.code_bytes),
      .pc         (req_bus.pc),
      .flags_reg  (req_bus.flags_reg),
      .reg_b      (req_bus.reg_b),
      .reg_hl     (req_bus.reg_hl),
      .reg_ix     (req_bus.reg_ix),
      .reg_iy     (req_bus.reg_iy),
      .stack_word (req_bus.stack_word),
      .scan       (scan_out)
   );

   // stage two: decode
   btp_decode u_decode (
      .scan (s1_ff),
      .dec  (dec_out)
   );

   // stage three: target select
   always_comb begin
      res_sel.is_branch     = s2_ff.is_branch;
      res_sel.from_register = s2_ff.from_register;
      res_sel.is_call       = s2_ff.is_call;
      res_sel.is_loop       = s2_ff.is_loop;
      res_sel.is_block      = s2_ff.is_block;
      res_sel.window_short  = s2_ff.window_short;
      unique case (s2_ff.tsel)
         TS_NONE:  res_sel.target_addr = 16'h0000;
         TS_STACK: res_sel.target_addr = s2_ff.stack_word;
         TS_BASE:  res_sel.target_addr = s2_ff.base;
         TS_WORD:  res_sel.target_addr = s2_ff.word_addr;
         TS_REL:   res_sel.target_addr = s2_ff.rel_addr;
         TS_RST:   res_sel.target_addr = {10'd0, s2_ff.rst_vec, 3'd0};
         default:  res_sel.target_addr = 16'h0000;
      endcase
   end

   // ready chain, back from the output register
   assign s3_ready = !s3_valid_ff || rsp_bus.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign req_bus.ready = s1_ready;

   // next stage contents
   always_comb begin
      s1_valid_in = s1_ready ? req_bus.valid : s1_valid_ff;
      s1_in       = s1_ready ? scan_out      : s1_ff;
      s2_valid_in = s2_ready ? s1_valid_ff   : s2_valid_ff;
      s2_in       = s2_ready ? dec_out       : s2_ff;
      s3_valid_in = s3_ready ? s2_valid_ff   : s3_valid_ff;
      s3_in       = s3_ready ? res_sel       : s3_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

   // result beat
   assign rsp_bus.valid         = s3_valid_ff;
   assign rsp_bus.target_addr   = s3_ff.target_addr;
   assign rsp_bus.is_branch     = s3_ff.is_branch;
   assign rsp_bus.from_register = s3_ff.from_register;
   assign rsp_bus.is_call       = s3_ff.is_call;
   assign rsp_bus.is_loop       = s3_ff.is_loop;
   assign rsp_bus.is_block      = s3_ff.is_block;
   assign rsp_bus.window_short  = s3_ff.window_short;

   // a stalled decode stage keeps its beat
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s3_ready) |=> (s2_valid_ff && $stable(s2_ff)))
      else $error("decode stage lost a beat while stalled");

   // calls and loops are always taken branches
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.is_call || rsp_bus.is_loop)) |-> rsp_bus.is_branch)
      else $error("call or loop flag without branch");

   // no target unless a branch is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.is_branch) |-> (rsp_bus.target_addr == 16'h0000))
      else $error("target address set without a branch");

   // a short window carries no other result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.window_short) |->
         (!rsp_bus.is_branch && !rsp_bus.is_block && !rsp_bus.from_register))
      else $error("short window result carries flags");

endmodule
`default_nettype wire
